// ----- hw/rtl/hbbic_pkg.sv -----
// Shared constants, codes and types for the hysteresis bang-bang integrator control unit.
// No dependencies; every other file of the block refers to it by scoped names.
package hbbic_pkg;

  // Window buffer geometry.
  localparam int WINDOW_LEN = 1024;
  localparam int IDX_W      = $clog2(WINDOW_LEN);

  // Field widths.
  localparam int RAW_W      = 12;
  localparam int CODE_W     = 16;
  localparam int CODE_SHIFT = 4;
  localparam int RIDX_W     = 11;
  localparam int CNT_W      = 10;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 2;

  // Stream payload widths.
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 48;

  // Item kinds carried on s_axis_tuser.
  localparam logic FUNC_PROCESS = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_THRESHOLD = 2'd1;

  // Reset values of the thresholds.
  localparam logic [THR_W-1:0] UPPER_RESET = 16'd58963;
  localparam logic [THR_W-1:0] LOWER_RESET = 16'd2601;

  // Last fill position of the window.
  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(WINDOW_LEN - 1);

  // Controller state as reported after an item.
  typedef struct packed {
    logic             phase_neg;
    logic [IDX_W-1:0] pos_cnt;
    logic [IDX_W-1:0] neg_cnt;
    logic [IDX_W-1:0] fill;
  } ctrl_state_t;

  // Read lookup outcome handed from the controller to the pipeline.
  typedef struct packed {
    logic in_range;
    logic hit;
  } read_info_t;

endpackage

// ----- hw/rtl/hysteresis_bang_bang_integrator_control_unit.sv -----
// Top level of the hysteresis bang-bang integrator control unit: handshakes and result pipeline.
// Depends on hbbic_pkg, hbbic_ctrl and hbbic_ram.
//
//  Channel   Direction  Handshake                      Beat contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser: func; tdata: adc_sample, read_index
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: state, counts, fill, read result
//  cfg       in         cfg_valid / cfg_ready          cfg_index selects threshold, cfg_data
//
// One beat is accepted per cycle while s_axis_tready is high; each beat yields one result beat.
// The rate is set by the sample memory, which has one write port and one read port; each
// beat needs at most one of them, so a beat can follow every cycle.
// Reset is synchronous; it restores the thresholds, clears phase, counters and fill tracking,
// and needs no memory clearing pass because unwritten entries are masked to zero.
// A stalled m_axis holds the output register; the input keeps accepting while the middle
// stage is free, so one further beat is absorbed before s_axis_tready drops.
module hysteresis_bang_bang_integrator_control_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [11:0] adc_sample, [22:12] read_index, [23] zero
  input  logic [hbbic_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] func
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] select_negative, [10:1] positive_count, [20:11] negative_count,
  // [30:21] fill_position, [46:31] read_data, [47] read_in_range
  output logic [hbbic_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hbbic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hbbic_pkg::THR_W-1:0]         cfg_data
);

  logic                             accept;
  logic                             proc_en;
  logic                             rd_en;
  logic [hbbic_pkg::RAW_W-1:0]      raw;
  logic [hbbic_pkg::RIDX_W-1:0]     ridx;
  logic [hbbic_pkg::IDX_W-1:0]      wr_addr;
  logic [hbbic_pkg::RAW_W-1:0]      rdata;
  hbbic_pkg::ctrl_state_t           report;
  hbbic_pkg::read_info_t            rd_info;

  // Middle stage: waits for the memory read data.
  logic                             p1_valid;
  hbbic_pkg::ctrl_state_t           p1_state;
  hbbic_pkg::read_info_t            p1_info;

  // Output stage.
  logic                             out_valid;
  logic                             out_free;
  logic                             out_sel_neg;
  logic [hbbic_pkg::CNT_W-1:0]      out_pos;
  logic [hbbic_pkg::CNT_W-1:0]      out_neg;
  logic [hbbic_pkg::CNT_W-1:0]      out_fill;
  logic [hbbic_pkg::CODE_W-1:0]     out_rdata;
  logic                             out_in_range;
  logic [hbbic_pkg::CODE_W-1:0]     rd_code;

  assign raw  = s_axis_tdata[hbbic_pkg::RAW_W-1:0];
  assign ridx = s_axis_tdata[hbbic_pkg::RAW_W +: hbbic_pkg::RIDX_W];

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = !p1_valid || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign proc_en       = accept && (s_axis_tuser == hbbic_pkg::FUNC_PROCESS);
  assign rd_en         = accept && (s_axis_tuser == hbbic_pkg::FUNC_READ);

  // Thresholds are always writable; the user must change them only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  hbbic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .proc_en  (proc_en),
    .rd_en    (rd_en),
    .raw      (raw),
    .ridx     (ridx),
    .wr_addr  (wr_addr),
    .report   (report),
    .rd_info  (rd_info)
  );

  // A read of an entry written by an earlier beat sees the new data, since the write
  // lands at the edge before the read is sampled; no forwarding path is needed.
  hbbic_ram u_ram (
    .clk  (clk),
    .we   (proc_en),
    .waddr(wr_addr),
    .wdata(raw),
    .re   (rd_en),
    .raddr(ridx[hbbic_pkg::IDX_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (accept) begin
      p1_valid <= 1'b1;
    end else if (out_free) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_state <= report;
      // Process beats report no read result.
      p1_info.in_range <= rd_en && rd_info.in_range;
      p1_info.hit      <= rd_en && rd_info.hit;
    end
  end

  // Entries never written since reset read as zero.
  assign rd_code = p1_info.hit ? {rdata, {hbbic_pkg::CODE_SHIFT{1'b0}}} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && p1_valid) begin
      out_sel_neg  <= p1_state.phase_neg;
      out_pos      <= hbbic_pkg::CNT_W'(p1_state.pos_cnt);
      out_neg      <= hbbic_pkg::CNT_W'(p1_state.neg_cnt);
      out_fill     <= hbbic_pkg::CNT_W'(p1_state.fill);
      out_rdata    <= rd_code;
      out_in_range <= p1_info.in_range;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_in_range, out_rdata, out_fill, out_neg, out_pos, out_sel_neg};

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    p1_valid && !out_free |-> !s_axis_tready)
    else $error("input accepted while the middle stage was blocked");

  a_no_data_out_of_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !out_in_range |-> out_rdata == '0)
    else $error("read data shown without an in-range read");

  a_p1_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    p1_valid && p1_info.hit |-> p1_info.in_range)
    else $error("memory hit outside the window");

endmodule

// ----- hw/rtl/hbbic_ram.sv -----
// Single-write, single-read synchronous memory holding the raw samples of the window.
// Depends on hbbic_pkg for depth and widths; read data is registered.
module hbbic_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [hbbic_pkg::IDX_W-1:0]  waddr,
  input  logic [hbbic_pkg::RAW_W-1:0]  wdata,
  input  logic                         re,
  input  logic [hbbic_pkg::IDX_W-1:0]  raddr,
  output logic [hbbic_pkg::RAW_W-1:0]  rdata
);

  logic [hbbic_pkg::RAW_W-1:0] mem [hbbic_pkg::WINDOW_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read register only moves when a read is issued, so it holds while the pipeline stalls.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/hbbic_ctrl.sv -----
// Hysteresis controller: thresholds, phase, phase counters, fill position and fill tracking.
// Depends on hbbic_pkg; drives the sample memory write port and classifies read items.
module hbbic_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [hbbic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbbic_pkg::THR_W-1:0]      cfg_data,
  input  logic                             proc_en,
  input  logic                             rd_en,
  input  logic [hbbic_pkg::RAW_W-1:0]      raw,
  input  logic [hbbic_pkg::RIDX_W-1:0]     ridx,
  output logic [hbbic_pkg::IDX_W-1:0]      wr_addr,
  output hbbic_pkg::ctrl_state_t           report,
  output hbbic_pkg::read_info_t            rd_info
);

  logic [hbbic_pkg::THR_W-1:0]  upper;
  logic [hbbic_pkg::THR_W-1:0]  lower;
  hbbic_pkg::ctrl_state_t       state;
  hbbic_pkg::ctrl_state_t       state_next;
  hbbic_pkg::ctrl_state_t       upd;
  logic                         filled;
  logic                         filled_next;
  logic [hbbic_pkg::CODE_W-1:0] code;
  logic                         wrap;

  // Thresholds.
  always_ff @(posedge clk) begin
    if (rst) begin
      upper <= hbbic_pkg::UPPER_RESET;
      lower <= hbbic_pkg::LOWER_RESET;
    end else if (cfg_we) begin
      if (cfg_index == hbbic_pkg::REG_UPPER_THRESHOLD) begin
        upper <= cfg_data;
      end else if (cfg_index == hbbic_pkg::REG_LOWER_THRESHOLD) begin
        lower <= cfg_data;
      end
    end
  end

  assign code = {raw, {hbbic_pkg::CODE_SHIFT{1'b0}}};
  assign wrap = (state.fill == hbbic_pkg::LAST_POS);

  // State after one processed sample.
  always_comb begin
    upd = state;
    if (!state.phase_neg) begin
      upd.pos_cnt = state.pos_cnt + 1'b1;
      if (code >= upper) begin
        upd.phase_neg = 1'b1;
      end
    end else begin
      upd.neg_cnt = state.neg_cnt + 1'b1;
      if (code <= lower) begin
        upd.phase_neg = 1'b0;
      end
    end
    upd.fill = state.fill + 1'b1;
    if (wrap) begin
      upd.fill    = '0;
      upd.pos_cnt = '0;
      upd.neg_cnt = '0;
    end
  end

  always_comb begin
    state_next  = state;
    filled_next = filled;
    if (proc_en) begin
      state_next = upd;
      if (wrap) begin
        filled_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= '0;
      filled <= 1'b0;
    end else begin
      state  <= state_next;
      filled <= filled_next;
    end
  end

  assign wr_addr = state.fill;
  assign report  = state_next;

  // Entries are written in order from zero, so an entry holds real data once the window
  // has wrapped or when it lies below the fill position; anything else still reads as zero.
  assign rd_info.in_range = ({1'b0, ridx} < (hbbic_pkg::RIDX_W + 1)'(hbbic_pkg::WINDOW_LEN));
  assign rd_info.hit      = rd_info.in_range &&
                            (filled || (ridx[hbbic_pkg::IDX_W-1:0] < state.fill));

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    proc_en && !wrap |=> state.fill == $past(state.fill) + 1'b1)
    else $error("fill position did not advance by one");

  a_wrap_clear: assert property (@(posedge clk) disable iff (rst)
    proc_en && wrap |=> filled && state.fill == '0 && state.pos_cnt == '0 &&
                        state.neg_cnt == '0)
    else $error("window wrap did not clear the counters");

  a_read_keeps: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> $stable(state) && $stable(filled))
    else $error("read item changed controller state");

endmodule
